>>> hw/rtl/trd_pkg.sv
// Shared types, codes and helper functions of the tracker record deframer.
// Depends on nothing; used by tracker_record_deframer_core.
`default_nettype none

package trd_pkg;

    localparam int unsigned MaxItems    = 16;
    localparam int unsigned MaxStations = 32;

    // Byte that opens a burst and marks the station number base.
    localparam logic [7:0] SYNC_BYTE = 8'h30;

    // Item codes of the format list.
    localparam logic [3:0] ITEM_SPACE  = 4'd0;
    localparam logic [3:0] ITEM_CRLF   = 4'd1;
    localparam logic [3:0] ITEM_POS    = 4'd2;
    localparam logic [3:0] ITEM_RELPOS = 4'd3;
    localparam logic [3:0] ITEM_ANGLES = 4'd4;
    localparam logic [3:0] ITEM_MATRIX = 4'd5;
    localparam logic [3:0] ITEM_QUAT   = 4'd6;
    localparam logic [3:0] ITEM_POS16  = 4'd7;
    localparam logic [3:0] ITEM_ANG16  = 4'd8;
    localparam logic [3:0] ITEM_QUAT16 = 4'd9;

    // Error codes of a result word.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_STATION = 2'd1;
    localparam logic [1:0] ERR_SYNC    = 2'd2;

    // Byte position within a record header; HDR_DATA means in the items.
    localparam logic [1:0] HDR_MARK    = 2'd0;
    localparam logic [1:0] HDR_STATION = 2'd1;
    localparam logic [1:0] HDR_STATUS  = 2'd2;
    localparam logic [1:0] HDR_DATA    = 2'd3;

    typedef enum logic [2:0] {
        CFG_FORMAT_LIST       = 3'd0,
        CFG_FORMAT_COUNT      = 3'd1,
        CFG_ACTIVE_STATIONS   = 3'd2,
        CFG_RECORDS_PER_BURST = 3'd3,
        CFG_STREAMING_MODE    = 3'd4
    } t_cfg_index;

    // Result of a search for the next supported item in the list.
    typedef struct packed {
        logic       found;
        logic [3:0] idx;
    } t_slot;

    function automatic logic [3:0] code_at(input logic [63:0] list, input logic [3:0] i);
        return list[{i, 2'b00} +: 4];
    endfunction

    // Elements in one item.
    function automatic logic [3:0] elems_of(input logic [3:0] k);
        logic [3:0] n;
        case (k) inside
            ITEM_MATRIX:                                 n = 4'd9;
            ITEM_QUAT, ITEM_QUAT16:                      n = 4'd4;
            ITEM_POS, ITEM_RELPOS, ITEM_ANGLES,
            ITEM_POS16, ITEM_ANG16:                      n = 4'd3;
            default:                                     n = 4'd1;
        endcase
        return n;
    endfunction

    // Bytes in one element.
    function automatic logic [2:0] elem_bytes(input logic [3:0] k);
        logic [2:0] n;
        if (k == ITEM_SPACE) begin
            n = 3'd1;
        end else if (k == ITEM_CRLF || k >= ITEM_POS16) begin
            n = 3'd2;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    // Lowest supported item at or above start and below count.
    function automatic t_slot next_supported(input logic [63:0] list,
                                             input logic [4:0]  count,
                                             input logic [4:0]  start);
        t_slot s;
        s = '0;
        for (int i = 0; i < MaxItems; i++) begin
            if (!s.found && 5'(i) >= start && 5'(i) < count &&
                code_at(list, 4'(i)) <= ITEM_QUAT16) begin
                s.found = 1'b1;
                s.idx   = 4'(i);
            end
        end
        return s;
    endfunction

    // Count set bits as a shallow tree: nibbles, then pairs, then the final sum.
    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [2:0] nib [8];
        logic [3:0] pair [4];
        logic [5:0] c;
        for (int j = 0; j < 8; j++) begin
            nib[j] = 3'(v[4*j]) + 3'(v[4*j+1]) + 3'(v[4*j+2]) + 3'(v[4*j+3]);
        end
        for (int j = 0; j < 4; j++) begin
            pair[j] = {1'b0, nib[2*j]} + {1'b0, nib[2*j+1]};
        end
        c = (6'(pair[0]) + 6'(pair[1])) + (6'(pair[2]) + 6'(pair[3]));
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tracker_record_deframer_core.sv
// Tracker record deframer: turns the tracker's serial bytes into decoded value words.
// Depends on trd_pkg (codes, item tables, list search, popcount).
`default_nettype none

//  channel   | direction | handshake                 | word
//  ----------+-----------+---------------------------+-----------------------------------
//  rx in     | in        | i_in_valid / o_in_ready   | i_rx_byte
//  result    | out       | o_out_valid / i_out_ready | tracker, kind, component, value,
//            |           |                           | error, record end, burst end
//  config    | in        | i_cfg_wr_en (no wait)     | i_cfg_index, i_cfg_wdata
//
// One byte is taken per cycle. A byte's decode is one pass of logic from the position
// registers and the byte to the result register; the longest path is the two searches
// for the next supported item. The result register holds one word: a new byte is taken
// whenever that register is empty or is being emptied in the same cycle, so a stall
// on the result side holds the input only while a word is waiting there.
// Reset is synchronous, active low, and clears configuration, positions (but not the
// assembly word) and the result valid flag at once; there is no clearing pass.

module tracker_record_deframer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    // result output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_tracker_index,
    output logic [3:0]       o_item_kind,
    output logic [3:0]       o_component,
    output logic [31:0]      o_value,
    output logic [1:0]       o_error_code,
    output logic             o_record_end,
    output logic             o_burst_end,
    // configuration writes
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_wdata
);

    // Configuration registers
    logic [63:0] r_format_list;
    logic [4:0]  r_format_count;
    logic [31:0] r_active_stations;
    logic [5:0]  r_records_per_burst;
    logic        r_streaming_mode;

    // Position state
    logic        r_hunting,        n_hunting;
    logic [5:0]  r_record_count,   n_record_count;
    logic [1:0]  r_header_pos,     n_header_pos;
    logic [3:0]  r_item_pos,       n_item_pos;
    logic [3:0]  r_element_pos,    n_element_pos;
    logic [1:0]  r_byte_pos,       n_byte_pos;
    logic [31:0] r_assembly_word,  n_assembly_word;
    logic [4:0]  r_current_tracker, n_current_tracker;
    logic        r_record_valid,   n_record_valid;

    // Result register
    logic        r_out_valid;
    logic [4:0]  r_tracker_index;
    logic [3:0]  r_item_kind;
    logic [3:0]  r_component;
    logic [31:0] r_value;
    logic [1:0]  r_error_code;
    logic        r_record_end;
    logic        r_burst_end;

    // Decode of the current byte
    logic        accept;
    logic        emit;
    logic        has_val;
    logic        rec_end;
    logic        bur_end;
    logic [1:0]  err;
    logic [3:0]  kind_o;
    logic [3:0]  comp_o;
    logic [31:0] val_o;

    logic [4:0]  items_n;
    logic [5:0]  rpb;
    logic [5:0]  count_inc;
    logic [7:0]  station;
    logic        station_ok;
    logic [31:0] below_mask;
    logic [5:0]  below_cnt;
    trd_pkg::t_slot slot_cur;
    trd_pkg::t_slot slot_next;
    logic [3:0]  cur_kind;
    logic [2:0]  byte_inc;
    logic [4:0]  elem_inc;
    logic [31:0] word_base;
    logic [31:0] word_new;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Clip the configured counts.
    assign items_n = (r_format_count > 5'(trd_pkg::MaxItems)) ?
                     5'(trd_pkg::MaxItems) : r_format_count;
    assign rpb     = (r_records_per_burst > 6'(trd_pkg::MaxStations)) ?
                     6'(trd_pkg::MaxStations) : r_records_per_burst;

    // Station byte: number, activity and tracker index (active stations below it).
    assign station    = i_rx_byte - trd_pkg::SYNC_BYTE;
    assign station_ok = (station >= 8'd1) && (station <= 8'(trd_pkg::MaxStations)) &&
                        r_active_stations[5'(station - 8'd1)];
    assign below_mask = r_active_stations &
                        ((32'd1 << 5'(station - 8'd1)) - 32'd1);
    assign below_cnt  = trd_pkg::popcount32(below_mask);

    // Item search: current item (skipping unsupported codes) and the one after it.
    assign slot_cur  = trd_pkg::next_supported(r_format_list, items_n, {1'b0, r_item_pos});
    assign slot_next = trd_pkg::next_supported(r_format_list, items_n,
                                               {1'b0, slot_cur.idx} + 5'd1);
    assign cur_kind  = trd_pkg::code_at(r_format_list, slot_cur.idx);

    assign byte_inc  = {1'b0, r_byte_pos} + 3'd1;
    assign elem_inc  = {1'b0, r_element_pos} + 5'd1;
    assign word_base = (r_byte_pos == 2'd0) ? 32'd0 : r_assembly_word;
    assign word_new  = word_base | ({24'd0, i_rx_byte} << {r_byte_pos, 3'b000});

    assign count_inc = r_record_count + 6'd1;

    always_comb begin
        n_hunting         = r_hunting;
        n_record_count    = r_record_count;
        n_header_pos      = r_header_pos;
        n_item_pos        = r_item_pos;
        n_element_pos     = r_element_pos;
        n_byte_pos        = r_byte_pos;
        n_assembly_word   = r_assembly_word;
        n_current_tracker = r_current_tracker;
        n_record_valid    = r_record_valid;
        err               = trd_pkg::ERR_NONE;
        rec_end           = 1'b0;
        bur_end           = 1'b0;
        has_val           = 1'b0;
        kind_o            = 4'd0;
        comp_o            = 4'd0;
        val_o             = 32'd0;

        if (r_hunting) begin
            // Hunt for sync: drop everything while no burst is configured, and in
            // streaming mode drop anything but the sync byte.
            if (rpb != 6'd0 &&
                (i_rx_byte == trd_pkg::SYNC_BYTE || !r_streaming_mode)) begin
                if (i_rx_byte != trd_pkg::SYNC_BYTE) begin
                    err = trd_pkg::ERR_SYNC;
                end
                n_hunting      = 1'b0;
                n_record_count = 6'd0;
                n_header_pos   = trd_pkg::HDR_STATION;
            end
        end else begin
            case (r_header_pos)
                trd_pkg::HDR_MARK: begin
                    n_header_pos = trd_pkg::HDR_STATION;
                end
                trd_pkg::HDR_STATION: begin
                    n_record_valid    = station_ok;
                    n_current_tracker = station_ok ? below_cnt[4:0] : 5'd0;
                    if (!station_ok) begin
                        err = trd_pkg::ERR_STATION;
                    end
                    n_header_pos = trd_pkg::HDR_STATUS;
                end
                trd_pkg::HDR_STATUS: begin
                    // Skip the status byte; item position is already zero here.
                    n_header_pos  = trd_pkg::HDR_DATA;
                    n_item_pos    = slot_cur.idx;
                    n_element_pos = 4'd0;
                    n_byte_pos    = 2'd0;
                    rec_end       = !slot_cur.found;
                end
                default: begin
                    if (!slot_cur.found) begin
                        rec_end = 1'b1;
                    end else begin
                        n_item_pos      = slot_cur.idx;
                        n_assembly_word = word_new;
                        if (byte_inc >= trd_pkg::elem_bytes(cur_kind)) begin
                            // Element complete: emit it if it carries data and the record's station is valid.
                            if (cur_kind >= trd_pkg::ITEM_POS && r_record_valid) begin
                                has_val = 1'b1;
                                kind_o  = cur_kind;
                                comp_o  = (cur_kind == trd_pkg::ITEM_QUAT) ?
                                          {2'b00, elem_inc[1:0]} : r_element_pos;
                                val_o   = (cur_kind >= trd_pkg::ITEM_POS16) ?
                                          {18'd0, word_new[14:8], word_new[6:0]} :
                                          word_new;
                            end
                            n_byte_pos = 2'd0;
                            if (elem_inc >= {1'b0, trd_pkg::elems_of(cur_kind)}) begin
                                n_element_pos = 4'd0;
                                n_item_pos    = slot_next.idx;
                                rec_end       = !slot_next.found;
                            end else begin
                                n_element_pos = elem_inc[3:0];
                            end
                        end else begin
                            n_byte_pos = byte_inc[1:0];
                        end
                    end
                end
            endcase
        end

        if (rec_end) begin
            // Close the record; close the burst once its count is met.
            n_header_pos  = trd_pkg::HDR_MARK;
            n_item_pos    = 4'd0;
            n_element_pos = 4'd0;
            n_byte_pos    = 2'd0;
            if (count_inc >= rpb) begin
                bur_end        = 1'b1;
                n_hunting      = 1'b1;
                n_record_count = 6'd0;
            end else begin
                n_record_count = count_inc;
            end
        end
    end

    assign emit = has_val || (err != trd_pkg::ERR_NONE) || rec_end;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_list       <= '0;
            r_format_count      <= '0;
            r_active_stations   <= '0;
            r_records_per_burst <= '0;
            r_streaming_mode    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                trd_pkg::CFG_FORMAT_LIST:       r_format_list       <= i_cfg_wdata;
                trd_pkg::CFG_FORMAT_COUNT:      r_format_count      <= i_cfg_wdata[4:0];
                trd_pkg::CFG_ACTIVE_STATIONS:   r_active_stations   <= i_cfg_wdata[31:0];
                trd_pkg::CFG_RECORDS_PER_BURST: r_records_per_burst <= i_cfg_wdata[5:0];
                trd_pkg::CFG_STREAMING_MODE:    r_streaming_mode    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Position state: advance on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting         <= 1'b1;
            r_record_count    <= '0;
            r_header_pos      <= trd_pkg::HDR_MARK;
            r_item_pos        <= '0;
            r_element_pos     <= '0;
            r_byte_pos        <= '0;
            r_current_tracker <= '0;
            r_record_valid    <= 1'b0;
        end else if (accept) begin
            r_hunting         <= n_hunting;
            r_record_count    <= n_record_count;
            r_header_pos      <= n_header_pos;
            r_item_pos        <= n_item_pos;
            r_element_pos     <= n_element_pos;
            r_byte_pos        <= n_byte_pos;
            r_current_tracker <= n_current_tracker;
            r_record_valid    <= n_record_valid;
        end
    end

    // Assembly word is cleared by the first byte of each element.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_assembly_word <= n_assembly_word;
        end
    end

    // Result register: load on a word, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_tracker_index <= n_record_valid ? n_current_tracker : 5'd0;
            r_item_kind     <= kind_o;
            r_component     <= comp_o;
            r_value         <= val_o;
            r_error_code    <= err;
            r_record_end    <= rec_end;
            r_burst_end     <= bur_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tracker_index = r_tracker_index;
    assign o_item_kind     = r_item_kind;
    assign o_component     = r_component;
    assign o_value         = r_value;
    assign o_error_code    = r_error_code;
    assign o_record_end    = r_record_end;
    assign o_burst_end     = r_burst_end;

    // While hunting no record is open.
    a_hunt_no_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hunting |-> (r_header_pos == trd_pkg::HDR_MARK))
        else $error("hunting with a record open");

    // A burst never holds more than the record limit.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_record_count < 6'(trd_pkg::MaxStations))
        else $error("record count out of range");

    // Partial elements only exist inside the data part of a record.
    a_byte_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_pos != 2'd0) |-> (r_header_pos == trd_pkg::HDR_DATA))
        else $error("byte position set outside record data");

    // A burst end is always also a record end.
    a_burst_is_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_burst_end) |-> o_record_end)
        else $error("burst end without record end");

    // A word with an error never carries a value.
    a_err_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != trd_pkg::ERR_NONE) |->
        (o_item_kind == 4'd0 && o_value == 32'd0))
        else $error("error word carries a value");

endmodule

`default_nettype wire
